// ===== rtl/acvs_pkg.sv =====
// shared types, codes and header check constants for the atm vp/vc cell switch
package acvs_pkg;

    localparam int VP_ENTRIES_DEF = 16;
    localparam int VC_ENTRIES_DEF = 64;
    localparam int PORTS_DEF      = 8;

    localparam logic [8:0] HEC_POLY  = 9'h107;
    localparam logic [7:0] HEC_COSET = 8'h55;
    localparam logic [7:0] HEC_TOP   = 8'h80;

    typedef enum logic [2:0] {
        CMD_SWITCH = 3'd0,
        CMD_ADD_VP = 3'd1,
        CMD_ADD_VC = 3'd2,
        CMD_DEL_VP = 3'd3,
        CMD_DEL_VC = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        ST_FWD  = 2'd0,
        ST_DROP = 2'd1,
        ST_DONE = 2'd2,
        ST_FAIL = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        TBL_IDLE,
        TBL_ADD,
        TBL_DEL,
        TBL_BUMP
    } tbl_op_t;

    typedef struct packed {
        logic [2:0]  port;
        logic [11:0] vpi;
        logic [15:0] vci;
    } conn_key_t;

    typedef struct packed {
        logic [2:0]  port;
        logic [11:0] vpi;
        logic [15:0] vci;
    } conn_dest_t;

    typedef struct packed {
        logic       hit;
        logic       full;
        conn_dest_t dest;
        logic [31:0] cells_next;
    } tbl_look_t;

    typedef struct packed {
        tbl_op_t    op;
        conn_dest_t dest;
    } tbl_wr_t;

    // syndrome of each header bit alone, crc-8 msb first, zero preset
    function automatic logic [31:0][7:0] hec_columns();
        logic [31:0][7:0] cols;
        logic [7:0]       acc;
        logic [31:0]      word;
        for (int i = 0; i < 32; i++)
        begin
            word = 32'b1 << i;
            acc  = '0;
            for (int b = 31; b >= 0; b--)
            begin
                if (((acc & HEC_TOP) != 8'h00) ^ word[b])
                begin
                    acc = {acc[6:0], 1'b0} ^ HEC_POLY[7:0];
                end
                else
                begin
                    acc = {acc[6:0], 1'b0};
                end
            end
            cols[i] = acc;
        end
        return cols;
    endfunction

    localparam logic [31:0][7:0] HEC_COLS = hec_columns();

    // crc is linear, so the check byte is the coset xor the per-bit syndromes
    function automatic logic [7:0] hec_of(input logic [31:0] hdr);
        logic [7:0] acc;
        acc = HEC_COSET;
        for (int i = 0; i < 32; i++)
        begin
            if (hdr[i])
            begin
                acc = acc ^ HEC_COLS[i];
            end
        end
        return acc;
    endfunction

endpackage

// ===== rtl/acvs_conn_table.sv =====
// associative connection table with per-entry cell counters
module acvs_conn_table #(
    parameter int ENTRIES = acvs_pkg::VC_ENTRIES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  acvs_pkg::conn_key_t key,
    input  acvs_pkg::tbl_wr_t   wr,
    output acvs_pkg::tbl_look_t look
);

    logic [ENTRIES-1:0]  valid_reg;
    acvs_pkg::conn_key_t  key_reg   [ENTRIES];
    acvs_pkg::conn_dest_t dest_reg  [ENTRIES];
    logic [31:0]          count_reg [ENTRIES];

    logic [ENTRIES-1:0] hit_vec;
    logic [ENTRIES-1:0] free_vec;
    logic [ENTRIES-1:0] first_free;

    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            hit_vec[i] = valid_reg[i] && (key_reg[i] == key);
        end
        free_vec   = ~valid_reg;
        // isolate lowest set bit
        first_free = free_vec & (~free_vec + ENTRIES'(1));
    end

    // entries are unique by key, so at most one hit and an and-or select suffices
    always_comb
    begin
        look.hit        = |hit_vec;
        look.full       = ~|free_vec;
        look.dest       = '0;
        look.cells_next = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (hit_vec[i])
            begin
                look.dest       = look.dest | dest_reg[i];
                look.cells_next = look.cells_next | (count_reg[i] + 32'd1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (wr.op == acvs_pkg::TBL_ADD && first_free[i])
                begin
                    valid_reg[i] <= 1'b1;
                end
                else if (wr.op == acvs_pkg::TBL_DEL && hit_vec[i])
                begin
                    valid_reg[i] <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (wr.op == acvs_pkg::TBL_ADD && first_free[i])
            begin
                key_reg[i]   <= key;
                dest_reg[i]  <= wr.dest;
                count_reg[i] <= '0;
            end
            else if (wr.op == acvs_pkg::TBL_BUMP && hit_vec[i])
            begin
                count_reg[i] <= count_reg[i] + 32'd1;
            end
        end
    end

endmodule

// ===== rtl/atm_cell_vpi_vci_switch_unit.sv =====
// atm cell switch top level: vp/vc lookup, header rewrite, hec, counters
//
//  channel  | dir | tuser          | tdata
//  s_axis   | in  | command [2:0]  | in_port, header_in, match_vpi, match_vci,
//           |     |                | out_port, new_vpi, new_vci (96 bits)
//  m_axis   | out | status [1:0]   | dest_port, header_out, hec_byte,
//           |     |                | conn_cells, drops_total (112 bits)
//
// one beat per cycle sustained while m_axis_tready stays high; a taken beat sits in
// the input register and passes the table compare into the result register, where
// it is shown as valid. table writes land as it moves into the result register,
// so the next beat sees them. reset empties both tables and clears the drop count.
// a stalled result register holds the input register, which then holds s_axis.
module atm_cell_vpi_vci_switch_unit #(
    parameter int VP_ENTRIES = acvs_pkg::VP_ENTRIES_DEF,
    parameter int VC_ENTRIES = acvs_pkg::VC_ENTRIES_DEF,
    parameter int PORTS      = acvs_pkg::PORTS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [95:0]  s_axis_tdata,  // in_port, header_in, match_vpi, match_vci,
                                        // out_port, new_vpi, new_vci, pad
    input  logic [2:0]   s_axis_tuser,  // command
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [111:0] m_axis_tdata,  // dest_port, header_out, hec_byte,
                                        // conn_cells, drops_total, pad
    output logic [1:0]   m_axis_tuser   // status
);

    // input register
    logic        in_valid_reg;
    logic [2:0]  cmd_reg;
    logic [2:0]  port_reg;
    logic [31:0] hdr_reg;
    logic [11:0] mvpi_reg;
    logic [15:0] mvci_reg;
    logic [2:0]  oport_reg;
    logic [11:0] nvpi_reg;
    logic [15:0] nvci_reg;

    // result register
    logic                out_valid_reg;
    acvs_pkg::status_t   status_reg,  status_next;
    logic [2:0]          dest_reg,    dest_next;
    logic [31:0]         hout_reg,    hout_next;
    logic [7:0]          hec_reg,     hec_next;
    logic [31:0]         cells_reg,   cells_next;
    logic [31:0]         drops_reg,   drops_next;

    logic fire;
    logic ports_ok;
    logic sw;

    acvs_pkg::conn_key_t vp_key, vc_key;
    acvs_pkg::tbl_look_t vp_look, vc_look;
    acvs_pkg::tbl_wr_t   vp_wr, vc_wr;
    acvs_pkg::tbl_op_t   vp_op, vc_op;

    assign fire          = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            cmd_reg   <= s_axis_tuser;
            port_reg  <= s_axis_tdata[2:0];
            hdr_reg   <= s_axis_tdata[34:3];
            mvpi_reg  <= s_axis_tdata[46:35];
            mvci_reg  <= s_axis_tdata[62:47];
            oport_reg <= s_axis_tdata[65:63];
            nvpi_reg  <= s_axis_tdata[77:66];
            nvci_reg  <= s_axis_tdata[93:78];
        end
    end

    // a cell is keyed by its own header, a table op by the match fields
    assign sw = (cmd_reg == acvs_pkg::CMD_SWITCH);

    always_comb
    begin
        vp_key.port = port_reg;
        vp_key.vpi  = sw ? hdr_reg[31:20] : mvpi_reg;
        vp_key.vci  = '0;
        vc_key.port = port_reg;
        vc_key.vpi  = vp_key.vpi;
        vc_key.vci  = sw ? hdr_reg[19:4] : mvci_reg;
    end

    assign ports_ok = (int'(port_reg) < PORTS) && (int'(oport_reg) < PORTS);

    acvs_conn_table #(
        .ENTRIES (VP_ENTRIES)
    ) u_vp_table (
        .clk   (clk),
        .rst_n (rst_n),
        .key   (vp_key),
        .wr    (vp_wr),
        .look  (vp_look)
    );

    acvs_conn_table #(
        .ENTRIES (VC_ENTRIES)
    ) u_vc_table (
        .clk   (clk),
        .rst_n (rst_n),
        .key   (vc_key),
        .wr    (vc_wr),
        .look  (vc_look)
    );

    always_comb
    begin
        status_next = acvs_pkg::ST_FAIL;
        dest_next   = '0;
        hout_next   = '0;
        cells_next  = '0;
        drops_next  = drops_reg;
        vp_op       = acvs_pkg::TBL_IDLE;
        vc_op       = acvs_pkg::TBL_IDLE;
        case (cmd_reg)
            acvs_pkg::CMD_SWITCH:
            begin
                if (vp_look.hit)
                begin
                    status_next = acvs_pkg::ST_FWD;
                    dest_next   = vp_look.dest.port;
                    hout_next   = {vp_look.dest.vpi, hdr_reg[19:0]};
                    cells_next  = vp_look.cells_next;
                    vp_op       = acvs_pkg::TBL_BUMP;
                end
                else if (vc_look.hit)
                begin
                    status_next = acvs_pkg::ST_FWD;
                    dest_next   = vc_look.dest.port;
                    hout_next   = {vc_look.dest.vpi, vc_look.dest.vci, hdr_reg[3:0]};
                    cells_next  = vc_look.cells_next;
                    vc_op       = acvs_pkg::TBL_BUMP;
                end
                else
                begin
                    status_next = acvs_pkg::ST_DROP;
                    drops_next  = drops_reg + 32'd1;
                end
            end
            acvs_pkg::CMD_ADD_VP:
            begin
                if (ports_ok && !vp_look.hit && !vp_look.full)
                begin
                    status_next = acvs_pkg::ST_DONE;
                    vp_op       = acvs_pkg::TBL_ADD;
                end
            end
            acvs_pkg::CMD_ADD_VC:
            begin
                // a vp entry on the same path shadows any vc entry
                if (ports_ok && !vp_look.hit && !vc_look.hit && !vc_look.full)
                begin
                    status_next = acvs_pkg::ST_DONE;
                    vc_op       = acvs_pkg::TBL_ADD;
                end
            end
            acvs_pkg::CMD_DEL_VP:
            begin
                if (vp_look.hit && vp_look.dest.port == oport_reg &&
                    vp_look.dest.vpi == nvpi_reg)
                begin
                    status_next = acvs_pkg::ST_DONE;
                    vp_op       = acvs_pkg::TBL_DEL;
                end
            end
            acvs_pkg::CMD_DEL_VC:
            begin
                if (vc_look.hit && vc_look.dest.port == oport_reg &&
                    vc_look.dest.vpi == nvpi_reg && vc_look.dest.vci == nvci_reg)
                begin
                    status_next = acvs_pkg::ST_DONE;
                    vc_op       = acvs_pkg::TBL_DEL;
                end
            end
            default:
            begin
                status_next = acvs_pkg::ST_FAIL;
            end
        endcase
        hec_next = (status_next == acvs_pkg::ST_FWD) ? acvs_pkg::hec_of(hout_next) : 8'h00;
    end

    // table writes only on the beat that moves into the result register
    always_comb
    begin
        vp_wr.op        = fire ? vp_op : acvs_pkg::TBL_IDLE;
        vp_wr.dest.port = oport_reg;
        vp_wr.dest.vpi  = nvpi_reg;
        vp_wr.dest.vci  = '0;
        vc_wr.op        = fire ? vc_op : acvs_pkg::TBL_IDLE;
        vc_wr.dest.port = oport_reg;
        vc_wr.dest.vpi  = nvpi_reg;
        vc_wr.dest.vci  = nvci_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            drops_reg     <= '0;
        end
        else
        begin
            if (fire)
            begin
                out_valid_reg <= 1'b1;
                drops_reg     <= drops_next;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            status_reg <= status_next;
            dest_reg   <= dest_next;
            hout_reg   <= hout_next;
            hec_reg    <= hec_next;
            cells_reg  <= cells_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = status_reg;
    assign m_axis_tdata  = {5'b0, drops_reg, cells_reg, hec_reg, hout_reg, dest_reg};

    // an add never lands on a key that is already present or in a full table
    assert property (@(posedge clk) disable iff (!rst_n)
        vp_wr.op == acvs_pkg::TBL_ADD |-> !vp_look.hit && !vp_look.full)
    else $error("vp add with duplicate key or full table");

    assert property (@(posedge clk) disable iff (!rst_n)
        vc_wr.op == acvs_pkg::TBL_ADD |-> !vp_look.hit && !vc_look.hit && !vc_look.full)
    else $error("vc add with conflicting key or full table");

    // a cell is counted against one connection at most
    assert property (@(posedge clk) disable iff (!rst_n)
        !(vp_wr.op == acvs_pkg::TBL_BUMP && vc_wr.op == acvs_pkg::TBL_BUMP))
    else $error("cell counted in both tables");

    // every dropped cell advances the drop count by one
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && status_next == acvs_pkg::ST_DROP |=> drops_reg == $past(drops_reg) + 32'd1)
    else $error("drop count did not advance");

endmodule
